// ----- hdl/fhm_pkg.sv -----
package fhm_pkg;

    typedef enum logic [1:0] {
        MODE_LOCK    = 2'd0,
        MODE_TRY     = 2'd1,
        MODE_UNLOCK  = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_TIMEOUT   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    // queue read address source
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_SCAN = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load_req;
        logic    set_status;
        t_status status;
        logic    take_owner;
        logic    free_owner;
        logic    pop_head;
        logic    clr_idx;
        logic    inc_idx;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_append;
        logic    wr_shift;
        logic    dec_count;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic  tid_zero;
        t_mode mode;
        logic  owner_eq_tid;
        logic  owner_zero;
        logic  count_zero;
        logic  count_full;
        logic  idx_at_end;
        logic  idx_last;
        logic  hit;
    } t_dp_stat;

endpackage

// ----- hdl/fhm_dp.sv -----
module fhm_dp
    import fhm_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int ID_BITS     = 8,
    parameter int CNT_W       = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  logic [ID_BITS-1:0] i_tid,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic [2:0]         o_status,
    output logic [ID_BITS-1:0] o_woken,
    output logic [ID_BITS-1:0] o_owner,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_owns
);

    localparam int PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int SUM_W = CNT_W + 1;

    logic [ID_BITS-1:0] r_mem [MAX_WAITERS];
    logic [ID_BITS-1:0] r_rd_data;

    t_mode              r_mode;
    logic [ID_BITS-1:0] r_tid;
    logic [ID_BITS-1:0] r_owner;
    logic [ID_BITS-1:0] r_woken;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_idx;
    t_status            r_status;

    logic [ID_BITS-1:0] r_o_woken;
    logic [ID_BITS-1:0] r_o_owner;
    logic [CNT_W-1:0]   r_o_count;
    logic               r_o_owns;
    t_status            r_o_status;

    logic [CNT_W-1:0]   rd_off;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               wr_en;
    logic [SUM_W-1:0]   idx_p1;
    logic [PTR_W-1:0]   n_head;

    // physical slot of a logical queue position; head + offset stays below 2*MAX_WAITERS
    function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_WAITERS)) begin
            sum = sum - SUM_W'(MAX_WAITERS);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign idx_p1 = SUM_W'(r_idx) + SUM_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_HEAD: rd_off = '0;
            RD_SCAN: rd_off = r_idx;
            RD_NEXT: rd_off = idx_p1[CNT_W-1:0];
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = slot(r_head, rd_off);
    assign wr_en   = i_cmd.wr_append | i_cmd.wr_shift;
    assign wr_addr = slot(r_head, i_cmd.wr_append ? r_count : r_idx);
    assign wr_data = i_cmd.wr_append ? r_tid : r_rd_data;
    assign n_head  = (r_head == PTR_W'(MAX_WAITERS - 1)) ? '0 : r_head + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.take_owner) begin
                r_owner <= r_tid;
            end else if (i_cmd.free_owner) begin
                r_owner <= '0;
            end else if (i_cmd.pop_head) begin
                r_owner <= r_rd_data;
            end
            if (i_cmd.pop_head) begin
                r_head <= n_head;
            end
            if (i_cmd.wr_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop_head || i_cmd.dec_count) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= idx_p1[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode  <= t_mode'(i_mode);
            r_tid   <= i_tid;
            r_woken <= '0;
        end else if (i_cmd.pop_head) begin
            r_woken <= r_rd_data;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_woken  <= r_woken;
            r_o_owner  <= r_owner;
            r_o_count  <= r_count;
            r_o_owns   <= (r_tid != '0) && (r_owner == r_tid);
        end
    end

    assign o_stat.tid_zero     = (r_tid == '0);
    assign o_stat.mode         = r_mode;
    assign o_stat.owner_eq_tid = (r_owner == r_tid);
    assign o_stat.owner_zero   = (r_owner == '0);
    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.count_full   = (r_count == CNT_W'(MAX_WAITERS));
    assign o_stat.idx_at_end   = (r_idx == r_count);
    assign o_stat.idx_last     = (idx_p1 == SUM_W'(r_count));
    assign o_stat.hit          = (r_rd_data == r_tid);

    assign o_status = r_o_status;
    assign o_woken  = r_o_woken;
    assign o_owner  = r_o_owner;
    assign o_count  = r_o_count;
    assign o_owns   = r_o_owns;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WAITERS))
        else $error("waiter count above queue depth");

    a_free_no_waiters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owner == '0) |-> (r_count == '0))
        else $error("waiters queued on a free lock");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan index past queue tail");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_append |-> (r_count < CNT_W'(MAX_WAITERS)) && (r_owner != '0))
        else $error("append into full queue or onto free lock");
`endif

endmodule

// ----- hdl/fhm_ctrl.sv -----
module fhm_ctrl
    import fhm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POP,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.clr_idx    = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_BUSY;
                n_state          = S_RESULT;
                if (!i_stat.tid_zero) begin
                    unique case (i_stat.mode)
                        MODE_LOCK: begin
                            if (i_stat.owner_eq_tid) begin
                                o_cmd.status = ST_BUSY;
                            end else if (i_stat.owner_zero) begin
                                o_cmd.take_owner = 1'b1;
                                o_cmd.status     = ST_OK;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        MODE_TRY: begin
                            if (i_stat.owner_zero) begin
                                o_cmd.take_owner = 1'b1;
                                o_cmd.status     = ST_OK;
                            end
                        end
                        MODE_UNLOCK: begin
                            if (!i_stat.owner_eq_tid) begin
                                o_cmd.status = ST_NOT_OWNER;
                            end else if (i_stat.count_zero) begin
                                o_cmd.free_owner = 1'b1;
                                o_cmd.status     = ST_OK;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_HEAD;
                                n_state      = S_POP;
                            end
                        end
                        MODE_TIMEOUT: begin
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (i_stat.idx_at_end) begin
                    // task not in queue
                    o_cmd.set_status = 1'b1;
                    n_state          = S_RESULT;
                    if (i_stat.mode == MODE_LOCK) begin
                        if (i_stat.count_full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_append = 1'b1;
                            o_cmd.status    = ST_QUEUED;
                        end
                    end else begin
                        o_cmd.status = i_stat.owner_eq_tid ? ST_OK : ST_TIMEOUT;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SCAN;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    if (i_stat.mode == MODE_LOCK) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_QUEUED;
                        n_state          = S_RESULT;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.idx_last) begin
                    o_cmd.dec_count  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_TIMEOUT;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_POP: begin
                o_cmd.pop_head   = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                n_state          = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // no beat is taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted beat not decoded");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites an untaken beat");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result beat dropped before taken");
`endif

endmodule

// ----- hdl/fifo_handoff_mutex.sv -----
// Hardware lock with a FIFO wait queue. Each s_axis beat is one request
// (tuser = mode, tdata = task id) and yields exactly one m_axis beat. Trylock,
// unlock, and lock of a free or self-owned lock are decided straight from the
// owner and count flags. Unlock with waiters reads the head of the queue memory
// and hands the lock to it. Lock of a held lock and timeout scan the queue with
// a read and a compare per queued entry, plus one end check at the tail, since
// the queue is a single-write, single-read memory with a registered read port.
// A timeout that removes a waiter then moves each later entry forward by a
// read and a write. One request is in work at a time; the next beat is taken
// once the result sits in the output register, even if it is not yet taken.
module fifo_handoff_mutex
    import fhm_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((ID_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,   // task_id
    input  logic [1:0]            s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // woken_task, current_owner, waiting_count, requester_owns
    output logic [((2 * ID_BITS + $clog2(MAX_WAITERS + 1) + 8) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [2:0]            m_axis_tuser    // status
);

    localparam int CNT_W    = $clog2(MAX_WAITERS + 1);
    localparam int M_BITS   = 2 * ID_BITS + CNT_W + 1;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [ID_BITS-1:0] woken;
    logic [ID_BITS-1:0] owner;
    logic [CNT_W-1:0]   count;
    logic               owns;

    fhm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fhm_dp #(
        .MAX_WAITERS (MAX_WAITERS),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (s_axis_tuser),
        .i_tid    (s_axis_tdata[ID_BITS-1:0]),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_status (m_axis_tuser),
        .o_woken  (woken),
        .o_owner  (owner),
        .o_count  (count),
        .o_owns   (owns)
    );

    assign m_axis_tdata = M_DATA_W'({owns, count, owner, woken});

endmodule
